// File: hw/rtl/mxt_pkg.sv
// Shared constants and types of the maximum subarray XOR trie block.
`default_nettype none

package mxt_pkg;

	localparam int DATA_W         = 32;
	localparam int KEY_BITS_DEF   = 32;
	localparam int NODE_COUNT_DEF = 32768;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_QUERY,
		WS_INSERT,
		WS_ALLOC,
		WS_LEAF,
		WS_DONE
	} walk_state_t;

	typedef struct packed {
		logic start;
		logic restart;
	} walk_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic overflow;
	} walk_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/max_xor_subarray_trie_core.sv
// Top level of the maximum subarray XOR block: stream ports, prefix and maximum, result register.
// The result word is set by the query walk and the insert walk over the trie, one level per
// cycle on the single node-memory port, and is then loaded into the result register.
// A new word is not taken before the last result is loaded: s_tready is high only while the
// walker is idle, and a result held by the sink stalls the walker.
// Reset (arst_n low): prefix, maximum, pool counter and overflow flag clear, the root starts
// empty in flip-flops; the node pool needs no clearing pass, nodes are zeroed when allocated.
`default_nettype none

module max_xor_subarray_trie_core #(
	parameter int KEY_BITS   = mxt_pkg::KEY_BITS_DEF,
	parameter int NODE_COUNT = mxt_pkg::NODE_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input words
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [mxt_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
	input  wire logic                       s_tuser,  // [0] first
	input  wire logic                       s_tlast,  // last
	// result words
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [mxt_pkg::DATA_W-1:0] m_tdata,  // [31:0] max_xor
	output logic                            m_tuser,  // [0] overflow
	output logic                            m_tlast   // is_last
);

	import mxt_pkg::*;

	localparam int NW = $clog2(NODE_COUNT);

	logic                s_accept;
	logic [KEY_BITS-1:0] prefix_q, best_q, prefix_d;
	logic                last_q;
	logic                drain_ok;
	logic [KEY_BITS-1:0] acc, cand, best_d;

	walk_cmd_t           cmd;
	walk_stat_t          stat;

	logic                mem_rd, mem_we;
	logic [NW-1:0]       mem_addr;
	logic [2*NW-1:0]     mem_wdata, mem_rdata;

	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;
	logic                out_user_q, out_last_q;

	assign s_tready = stat.idle;
	assign s_accept = s_tvalid && s_tready;

	// A first word restarts the array: fold its value into an empty prefix.
	assign prefix_d = (s_tuser ? '0 : prefix_q) ^ s_tdata[KEY_BITS-1:0];

	assign cmd.start   = s_accept;
	assign cmd.restart = s_tuser;

	// Result slot is free when empty or draining this cycle.
	assign drain_ok = !out_valid_q || m_tready;

	// Implicit empty prefix: the prefix itself is a candidate next to the trie walk.
	assign cand   = (prefix_q > acc) ? prefix_q : acc;
	assign best_d = (cand > best_q) ? cand : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			best_q   <= '0;
		end else begin
			if (s_accept) begin
				prefix_q <= prefix_d;
				if (s_tuser) begin
					best_q <= '0;
				end
			end else if (stat.done && drain_ok) begin
				best_q <= best_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			last_q <= s_tlast;
		end
	end

	// Hold the result until the sink takes it; load the next one as it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && drain_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && drain_ok) begin
			out_data_q <= DATA_W'(best_d);
			out_user_q <= stat.overflow;
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	mxt_walker #(
		.KEY_BITS   (KEY_BITS),
		.NODE_COUNT (NODE_COUNT),
		.NW         (NW)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (prefix_d),
		.drain_ok  (drain_ok),
		.stat      (stat),
		.acc       (acc),
		.mem_rd    (mem_rd),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	mxt_node_mem #(
		.NODE_COUNT (NODE_COUNT),
		.NW         (NW)
	) u_node_mem (
		.clk   (clk),
		.rd    (mem_rd),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mxt_node_mem.sv
// Single-port node pool: one entry per trie node, {one child, zero child}.
`default_nettype none

module mxt_node_mem #(
	parameter int NODE_COUNT = 32768,
	parameter int NW         = $clog2(NODE_COUNT)
) (
	input  wire logic            clk,
	input  wire logic            rd,
	input  wire logic            we,
	input  wire logic [NW-1:0]   addr,
	input  wire logic [2*NW-1:0] wdata,
	output logic      [2*NW-1:0] rdata
);

	logic [2*NW-1:0] mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mxt_walker.sv
// Trie walk sequencer: greedy query walk, then insert walk with node allocation.
`default_nettype none

module mxt_walker #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_COUNT = 32768,
	parameter int NW         = $clog2(NODE_COUNT)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mxt_pkg::walk_cmd_t  cmd,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic                drain_ok,
	output mxt_pkg::walk_stat_t      stat,
	output logic      [KEY_BITS-1:0] acc,
	output logic                     mem_rd,
	output logic                     mem_we,
	output logic      [NW-1:0]       mem_addr,
	output logic      [2*NW-1:0]     mem_wdata,
	input  wire logic [2*NW-1:0]     mem_rdata
);

	import mxt_pkg::*;

	localparam int LW = $clog2(KEY_BITS);
	localparam logic [NW:0] POOL_END = (NW+1)'(NODE_COUNT);

	walk_state_t       state_q, state_d;
	logic [LW-1:0]     lvl_q;
	logic [NW-1:0]     node_q;
	logic [KEY_BITS-1:0] acc_q, key_q;
	logic [NW:0]       next_free_q;
	logic              ovf_q;
	logic [NW-1:0]     root_z_q, root_o_q;

	logic              at_root, cur_bit, last_lvl, pool_full;
	logic [NW-1:0]     cz, co, same, opp, nf;

	// Step controls from the combinational block
	logic              lvl_load, lvl_dec, node_load, acc_set, alloc, set_ovf, root_wr;
	logic [NW-1:0]     node_d;

	assign at_root   = (node_q == '0);
	assign cz        = at_root ? root_z_q : mem_rdata[NW-1:0];
	assign co        = at_root ? root_o_q : mem_rdata[2*NW-1:NW];
	assign cur_bit   = key_q[lvl_q];
	assign same      = cur_bit ? co : cz;
	assign opp       = cur_bit ? cz : co;
	assign last_lvl  = (lvl_q == '0);
	assign pool_full = (next_free_q >= POOL_END);
	assign nf        = next_free_q[NW-1:0];

	always_comb begin
		state_d   = state_q;
		lvl_load  = 1'b0;
		lvl_dec   = 1'b0;
		node_load = 1'b0;
		node_d    = '0;
		acc_set   = 1'b0;
		alloc     = 1'b0;
		set_ovf   = 1'b0;
		root_wr   = 1'b0;
		mem_rd    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = node_q;
		mem_wdata = '0;
		case (state_q)
			WS_IDLE: begin
				if (cmd.start) begin
					state_d = WS_QUERY;
				end
			end
			WS_QUERY: begin
				// prefer the opposite bit, fall back to the same bit, stop on a dead end
				if (opp != '0 || same != '0) begin
					acc_set = (opp != '0);
					node_d  = (opp != '0) ? opp : same;
				end
				if ((opp != '0 || same != '0) && !last_lvl) begin
					mem_rd    = 1'b1;
					mem_addr  = node_d;
					node_load = 1'b1;
					lvl_dec   = 1'b1;
				end else begin
					node_load = 1'b1;
					node_d    = '0;
					lvl_load  = 1'b1;
					state_d   = WS_INSERT;
				end
			end
			WS_INSERT: begin
				if (same != '0) begin
					if (last_lvl) begin
						state_d = WS_DONE;
					end else begin
						mem_rd    = 1'b1;
						mem_addr  = same;
						node_load = 1'b1;
						node_d    = same;
						lvl_dec   = 1'b1;
					end
				end else if (pool_full) begin
					set_ovf = 1'b1;
					state_d = WS_DONE;
				end else begin
					// hook a fresh node under the existing parent
					alloc     = 1'b1;
					root_wr   = at_root;
					mem_we    = !at_root;
					mem_wdata = cur_bit ? {nf, cz} : {co, nf};
					node_load = 1'b1;
					node_d    = nf;
					lvl_dec   = !last_lvl;
					state_d   = last_lvl ? WS_LEAF : WS_ALLOC;
				end
			end
			WS_ALLOC: begin
				// node is fresh: both children absent until written here
				mem_we = 1'b1;
				if (pool_full) begin
					set_ovf = 1'b1;
					state_d = WS_DONE;
				end else begin
					alloc     = 1'b1;
					mem_wdata = cur_bit ? {nf, {NW{1'b0}}} : {{NW{1'b0}}, nf};
					node_load = 1'b1;
					node_d    = nf;
					lvl_dec   = !last_lvl;
					state_d   = last_lvl ? WS_LEAF : WS_ALLOC;
				end
			end
			WS_LEAF: begin
				mem_we  = 1'b1;
				state_d = WS_DONE;
			end
			WS_DONE: begin
				if (drain_ok) begin
					state_d = WS_IDLE;
				end
			end
			default: begin
				state_d = WS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= (NW+1)'(1);
			ovf_q       <= 1'b0;
			root_z_q    <= '0;
			root_o_q    <= '0;
		end else begin
			if (state_q == WS_IDLE && cmd.start && cmd.restart) begin
				next_free_q <= (NW+1)'(1);
				ovf_q       <= 1'b0;
				root_z_q    <= '0;
				root_o_q    <= '0;
			end else begin
				if (alloc) begin
					next_free_q <= next_free_q + (NW+1)'(1);
				end
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
				if (root_wr) begin
					if (cur_bit) begin
						root_o_q <= nf;
					end else begin
						root_z_q <= nf;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WS_IDLE && cmd.start) begin
			key_q  <= key;
			acc_q  <= '0;
			node_q <= '0;
			lvl_q  <= LW'(KEY_BITS - 1);
		end else begin
			if (acc_set) begin
				acc_q[lvl_q] <= 1'b1;
			end
			if (node_load) begin
				node_q <= node_d;
			end
			if (lvl_load) begin
				lvl_q <= LW'(KEY_BITS - 1);
			end else if (lvl_dec) begin
				lvl_q <= lvl_q - LW'(1);
			end
		end
	end

	assign acc           = acc_q;
	assign stat.idle     = (state_q == WS_IDLE);
	assign stat.done     = (state_q == WS_DONE);
	assign stat.overflow = ovf_q;

endmodule

`default_nettype wire
